/* design/htt_pkg.sv */
// ----------------------------------------------------------------------------
// htt_pkg: shared types and constants for the HTML tag tokenizer
// Item layouts, parse phase codes, result kinds, error codes, characters.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

   localparam int TokLenW = 7;
   localparam logic [TokLenW-1:0] MaxTokenLen = TokLenW'(64);

   // parse phase codes
   localparam int PhaseW = 4;
   localparam logic [PhaseW-1:0] PhWaitLt   = 4'd0;
   localparam logic [PhaseW-1:0] PhAfterLt  = 4'd1;
   localparam logic [PhaseW-1:0] PhTagName  = 4'd2;
   localparam logic [PhaseW-1:0] PhAttrSkip = 4'd3;
   localparam logic [PhaseW-1:0] PhAttrName = 4'd4;
   localparam logic [PhaseW-1:0] PhAttrAftr = 4'd5;
   localparam logic [PhaseW-1:0] PhValSpace = 4'd6;
   localparam logic [PhaseW-1:0] PhValQ     = 4'd7;
   localparam logic [PhaseW-1:0] PhValUnq   = 4'd8;
   localparam logic [PhaseW-1:0] PhDone     = 4'd9;

   // result kinds
   localparam logic [2:0] KindTag  = 3'd0;
   localparam logic [2:0] KindAttr = 3'd1;
   localparam logic [2:0] KindVal  = 3'd2;
   localparam logic [2:0] KindEnd  = 3'd3;
   localparam logic [2:0] KindErr  = 3'd4;

   // error codes
   localparam logic [1:0] ErrNone    = 2'd0;
   localparam logic [1:0] ErrNoLt    = 2'd1;
   localparam logic [1:0] ErrBadName = 2'd2;
   localparam logic [1:0] ErrTooLong = 2'd3;

   // characters
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChLt    = 8'h3C;
   localparam logic [7:0] ChEq    = 8'h3D;
   localparam logic [7:0] ChGt    = 8'h3E;

   typedef struct packed {
      logic [7:0] ch;
      logic       begin_req;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [2:0] kind;
      logic       token_start;
      logic       closing;
      logic [1:0] error_code;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [PhaseW-1:0]  phase;
      logic               closing;
      logic [TokLenW-1:0] tlen;
   } parse_state_type;

endpackage

`default_nettype wire

/* design/htt_step.sv */
// ----------------------------------------------------------------------------
// htt_step: next-state and result logic for one byte
// Pure combinational decode of the current parse state and the input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_step (
   input  wire htt_pkg::req_item_type    item,
   input  wire htt_pkg::parse_state_type cur,
   output htt_pkg::parse_state_type      nxt,
   output logic                          fire,
   output htt_pkg::rsp_item_type         result
);

   htt_pkg::parse_state_type eff;
   logic [7:0]                 c;
   logic                       letter;
   logic                       emit;
   logic [2:0]                 ekind;
   logic                       fin;
   logic [1:0]                 err;
   logic [htt_pkg::TokLenW-1:0] base_len;

   assign c      = item.ch;
   assign letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

   // begin_req restarts the parser before the byte is handled
   always_comb begin
      if (item.begin_req) begin
         eff.phase   = htt_pkg::PhWaitLt;
         eff.closing = 1'b0;
         eff.tlen    = '0;
      end else begin
         eff = cur;
      end
   end

   always_comb begin
      nxt      = eff;
      emit     = 1'b0;
      ekind    = htt_pkg::KindTag;
      fin      = 1'b0;
      err      = htt_pkg::ErrNone;
      base_len = eff.tlen;
      unique case (eff.phase) inside
         htt_pkg::PhWaitLt: begin
            if (c == htt_pkg::ChLt) nxt.phase = htt_pkg::PhAfterLt;
            else if (c != htt_pkg::ChSpace) err = htt_pkg::ErrNoLt;
         end
         htt_pkg::PhAfterLt, htt_pkg::PhTagName: begin
            if (eff.phase == htt_pkg::PhAfterLt) begin
               base_len  = '0;
               nxt.phase = htt_pkg::PhTagName;
            end
            if (eff.phase == htt_pkg::PhAfterLt && c == htt_pkg::ChSlash) begin
               nxt.closing = 1'b1;
            end else if (letter) begin
               emit  = 1'b1;
               ekind = htt_pkg::KindTag;
            end else if ((c == htt_pkg::ChSpace || c == htt_pkg::ChGt) && base_len != '0) begin
               if (eff.closing || c == htt_pkg::ChGt) fin = 1'b1;
               else nxt.phase = htt_pkg::PhAttrSkip;
            end else begin
               err = htt_pkg::ErrBadName;
            end
         end
         htt_pkg::PhAttrSkip, htt_pkg::PhAttrAftr: begin
            if (c == htt_pkg::ChSpace || c == htt_pkg::ChSlash) begin
               nxt.phase = eff.phase;
            end else if (c == htt_pkg::ChGt) begin
               fin = 1'b1;
            end else if (c == htt_pkg::ChEq) begin
               nxt.phase = htt_pkg::PhValSpace;
            end else if (letter) begin
               base_len  = '0;
               nxt.phase = htt_pkg::PhAttrName;
               emit      = 1'b1;
               ekind     = htt_pkg::KindAttr;
            end else begin
               err = htt_pkg::ErrBadName;
            end
         end
         htt_pkg::PhAttrName: begin
            if (letter) begin
               emit  = 1'b1;
               ekind = htt_pkg::KindAttr;
            end else if (c == htt_pkg::ChSpace || c == htt_pkg::ChSlash) begin
               nxt.phase = htt_pkg::PhAttrAftr;
            end else if (c == htt_pkg::ChEq) begin
               nxt.phase = htt_pkg::PhValSpace;
            end else if (c == htt_pkg::ChGt) begin
               fin = 1'b1;
            end else begin
               err = htt_pkg::ErrBadName;
            end
         end
         htt_pkg::PhValSpace: begin
            if (c != htt_pkg::ChSpace) begin
               base_len = '0;
               if (c == htt_pkg::ChSlash) begin
                  nxt.phase = htt_pkg::PhValUnq;
                  emit      = 1'b1;
                  ekind     = htt_pkg::KindVal;
               end else begin
                  // any other byte opens a quoted value
                  nxt.phase = htt_pkg::PhValQ;
               end
            end
         end
         htt_pkg::PhValQ: begin
            if (c == htt_pkg::ChQuote) begin
               nxt.phase = htt_pkg::PhAttrSkip;
            end else begin
               emit  = 1'b1;
               ekind = htt_pkg::KindVal;
            end
         end
         htt_pkg::PhValUnq: begin
            if (c == htt_pkg::ChSpace) begin
               nxt.phase = htt_pkg::PhAttrSkip;
            end else if (c == htt_pkg::ChGt) begin
               fin = 1'b1;
            end else begin
               emit  = 1'b1;
               ekind = htt_pkg::KindVal;
            end
         end
         default: nxt.phase = htt_pkg::PhDone;
      endcase

      nxt.tlen = base_len;
      if (emit) begin
         if (base_len >= htt_pkg::MaxTokenLen) err = htt_pkg::ErrTooLong;
         else nxt.tlen = base_len + htt_pkg::TokLenW'(1);
      end

      fire               = 1'b0;
      result.out_char    = 8'h00;
      result.kind        = htt_pkg::KindTag;
      result.token_start = 1'b0;
      result.closing     = nxt.closing;
      result.error_code  = htt_pkg::ErrNone;
      result.last        = 1'b0;
      if (err != htt_pkg::ErrNone) begin
         nxt.phase         = htt_pkg::PhDone;
         fire              = 1'b1;
         result.kind       = htt_pkg::KindErr;
         result.error_code = err;
         result.last       = 1'b1;
      end else if (fin) begin
         nxt.phase   = htt_pkg::PhDone;
         fire        = 1'b1;
         result.kind = htt_pkg::KindEnd;
         result.last = 1'b1;
      end else if (emit) begin
         fire               = 1'b1;
         result.out_char    = c;
         result.kind        = ekind;
         result.token_start = (base_len == '0);
      end
   end

endmodule

`default_nettype wire

/* design/htt_out_buf.sv */
// ----------------------------------------------------------------------------
// htt_out_buf: two-entry result queue
// Result register plus skid entry; lets the parser keep going one item ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_out_buf (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire htt_pkg::rsp_item_type   push_item,
   output logic                         full,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output htt_pkg::rsp_item_type        rsp_item
);

   htt_pkg::rsp_item_type head_ff, head_in;
   htt_pkg::rsp_item_type tail_ff, tail_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_item  = head_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            head_in = push_item;
         end else begin
            head_in = tail_ff;
            tail_in = push_item;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) head_in = push_item;
         else tail_in = push_item;
         cnt_in = cnt_ff + 2'd1;
      end else if (pop) begin
         head_in = tail_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop))
      else $error("push into full result queue");

   a_shift_up: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && cnt_ff == 2'd2) |=> (head_ff == $past(tail_ff)))
      else $error("skid entry not moved to head");

endmodule

`default_nettype wire

/* design/html_tag_tokenizer.sv */
// ----------------------------------------------------------------------------
// html_tag_tokenizer: streaming tokenizer for the text of one HTML tag
// One byte per item in; tag name, attribute name/value bytes, end and errors out.
// ----------------------------------------------------------------------------
// Results: each result is pushed into the result queue as its byte is accepted.
// Throughput: one byte per cycle unless stalled; the parse state is registered.
// req_stall rises only while both entries of the two-deep result queue are full.
// Reset (synchronous, active high): parser waits for '<', closing flag and
// token length clear, result queue empties.
// ----------------------------------------------------------------------------
`default_nettype none

module html_tag_tokenizer (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire htt_pkg::req_item_type  req_item,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output htt_pkg::rsp_item_type       rsp_item
);

   // parse state register
   htt_pkg::parse_state_type state_ff, state_in;
   htt_pkg::parse_state_type step_nxt;
   htt_pkg::rsp_item_type    step_result;
   logic                     step_fire;
   logic                     accept;
   logic                     q_full;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // decode of one byte against the current state
   htt_step u_step (
      .item   (req_item),
      .cur    (state_ff),
      .nxt    (step_nxt),
      .fire   (step_fire),
      .result (step_result)
   );

   // state advances only on an accepted byte
   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= htt_pkg::PhWaitLt;
         state_ff.closing <= 1'b0;
         state_ff.tlen    <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register with skid entry
   htt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_fire),
      .push_item (step_result),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // tag end and error are the only final results
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |->
         (rsp_item.kind == htt_pkg::KindEnd || rsp_item.kind == htt_pkg::KindErr))
      else $error("last flag on a character result");

   // token length never passes the limit
   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.tlen <= htt_pkg::MaxTokenLen)
      else $error("token length beyond limit");

   // a final result leaves the parser done
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && step_fire && step_result.last) |=> (state_ff.phase == htt_pkg::PhDone))
      else $error("parser not done after final result");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the HTML tag tokenizer
// Streams tag bytes in, predicts every token/end/error result in a scoreboard
// class and compares results in order, under random idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;
   import htt_pkg::*;

   localparam int TotalItems    = 600;
   localparam int MaxGap        = 14;
   localparam int HoldCycles    = 200;   // long receiver hold-off, fills the block
   localparam int WatchdogLimit = 2000;  // idle cycles, several times the longest legal pause
   localparam int DrainCycles   = 8;

   // -------------------------------------------------------------------------
   // scoreboard: tracks the parser state of the block and keeps the results
   // it has to produce, oldest first
   // -------------------------------------------------------------------------
   class token_scoreboard;
      logic [PhaseW-1:0]  phase;
      logic               closing_tag;
      logic [TokLenW-1:0] tok_len;
      rsp_item_type       expected_tokens[$];
      int                 mismatches;

      function new();
         phase       = PhWaitLt;
         closing_tag = 1'b0;
         tok_len     = '0;
         mismatches  = 0;
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      function void push_token(logic [7:0] c, logic [2:0] kind, logic start,
                               logic [1:0] err, logic last);
         rsp_item_type t;
         t.out_char    = c;
         t.kind        = kind;
         t.token_start = start;
         t.closing     = closing_tag;
         t.error_code  = err;
         t.last        = last;
         expected_tokens.push_back(t);
      endfunction

      // tag end or error: both close the tag, nothing more until begin_req
      function void stop_tag(logic [2:0] kind, logic [1:0] err);
         phase = PhDone;
         push_token(8'h00, kind, 1'b0, err, 1'b1);
      endfunction

      function void emit_char(logic [7:0] c, logic [2:0] kind);
         logic start;
         start = (tok_len == 0);
         if (tok_len >= MaxTokenLen) begin
            stop_tag(KindErr, ErrTooLong);
         end else begin
            tok_len = tok_len + 1'b1;
            push_token(c, kind, start, ErrNone, 1'b0);
         end
      endfunction

      function void note_byte(req_item_type it);
         logic [7:0] c;
         c = it.ch;
         if (it.begin_req) begin
            phase       = PhWaitLt;
            closing_tag = 1'b0;
            tok_len     = '0;
         end
         // byte right after '<': slash marks a closing tag, else it is the
         // first byte of the name
         if (phase == PhAfterLt) begin
            tok_len = '0;
            phase   = PhTagName;
            if (c == ChSlash) begin
               closing_tag = 1'b1;
               return;
            end
         end
         case (phase)
            PhWaitLt: begin
               if (c == ChLt) phase = PhAfterLt;
               else if (c != ChSpace) stop_tag(KindErr, ErrNoLt);
            end
            PhTagName: begin
               if (is_letter(c)) begin
                  emit_char(c, KindTag);
               end else if ((c == ChSpace || c == ChGt) && tok_len != 0) begin
                  if (closing_tag || c == ChGt) stop_tag(KindEnd, ErrNone);
                  else phase = PhAttrSkip;
               end else begin
                  stop_tag(KindErr, ErrBadName);
               end
            end
            PhAttrSkip, PhAttrAftr: begin
               if (c == ChGt) begin
                  stop_tag(KindEnd, ErrNone);
               end else if (c == ChEq) begin
                  phase = PhValSpace;
               end else if (is_letter(c)) begin
                  tok_len = '0;
                  phase   = PhAttrName;
                  emit_char(c, KindAttr);
               end else if (c != ChSpace && c != ChSlash) begin
                  stop_tag(KindErr, ErrBadName);
               end
            end
            PhAttrName: begin
               if (is_letter(c)) emit_char(c, KindAttr);
               else if (c == ChSpace || c == ChSlash) phase = PhAttrAftr;
               else if (c == ChEq) phase = PhValSpace;
               else if (c == ChGt) stop_tag(KindEnd, ErrNone);
               else stop_tag(KindErr, ErrBadName);
            end
            PhValSpace: begin
               if (c != ChSpace) begin
                  tok_len = '0;
                  if (c == ChSlash) begin
                     phase = PhValUnq;
                     emit_char(c, KindVal);
                  end else begin
                     phase = PhValQ;  // any other byte opens a quoted value
                  end
               end
            end
            PhValQ: begin
               if (c == ChQuote) phase = PhAttrSkip;
               else emit_char(c, KindVal);
            end
            PhValUnq: begin
               if (c == ChSpace) phase = PhAttrSkip;
               else if (c == ChGt) stop_tag(KindEnd, ErrNone);
               else emit_char(c, KindVal);
            end
            default: phase = PhDone;
         endcase
      endfunction

      function void check_token(rsp_item_type got);
         rsp_item_type want;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: char %h kind %0d start %0b closing %0b err %0d last %0b",
                        got.out_char, got.kind, got.token_start, got.closing,
                        got.error_code, got.last);
         end else begin
            want = expected_tokens.pop_front();
            if (want.out_char !== got.out_char || want.kind !== got.kind ||
                want.token_start !== got.token_start || want.closing !== got.closing ||
                want.error_code !== got.error_code || want.last !== got.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected char %h kind %0d start %0b closing %0b",
                            " err %0d last %0b, got char %h kind %0d start %0b closing %0b",
                            " err %0d last %0b"},
                           want.out_char, want.kind, want.token_start, want.closing,
                           want.error_code, want.last,
                           got.out_char, got.kind, got.token_start, got.closing,
                           got.error_code, got.last);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, block under test
   // -------------------------------------------------------------------------
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   initial begin
      forever #6 clock = ~clock;
   end

   html_tag_tokenizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   token_scoreboard sb = new();

   int           items_sent   = 0;
   bit           sender_calm  = 1'b0;  // no gaps for the current tag
   bit           hold_request = 1'b0;  // asks the receiver for one long hold-off
   bit           hold_active  = 1'b0;
   bit           hold_done    = 1'b0;
   req_item_type pend_items[$];        // bytes of the tag about to be sent

   // -------------------------------------------------------------------------
   // byte stream builders
   // -------------------------------------------------------------------------
   function void push_ch(logic [7:0] c);
      req_item_type it;
      it.ch        = c;
      it.begin_req = (pend_items.size() == 0);
      pend_items.push_back(it);
   endfunction

   function void load_text(string s);
      pend_items.delete();
      for (int i = 0; i < s.len(); i++) push_ch(s[i]);
   endfunction

   function logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   // most tokens short; now and then one around the length limit
   function int draw_len();
      if ($urandom_range(0, 11) == 0) return $urandom_range(62, 67);
      return $urandom_range(1, 6);
   endfunction

   function void add_letters(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 51);
         push_ch(r < 26 ? 8'("A" + r) : 8'("a" + r - 26));
      end
   endfunction

   // one tag: mostly well-formed with random content, some broken or noise
   function void build_tag();
      int n;
      int vmode;
      bit empty_name;
      pend_items.delete();
      if ($urandom_range(0, 9) == 0) begin
         // noise, with an occasional restart in the middle
         n = $urandom_range(1, 8);
         repeat (n) push_ch(8'($urandom_range(0, 255)));
         foreach (pend_items[i])
            if (i > 0 && $urandom_range(0, 7) == 0) pend_items[i].begin_req = 1'b1;
      end else begin
         repeat ($urandom_range(0, 2)) push_ch(ChSpace);
         push_ch(ChLt);
         if ($urandom_range(0, 3) == 0) begin
            push_ch(ChSlash);
            add_letters(draw_len());
            push_ch($urandom_range(0, 1) ? ChGt : ChSpace);
         end else begin
            add_letters(draw_len());
            repeat ($urandom_range(0, 3)) begin
               push_ch(ChSpace);
               if ($urandom_range(0, 5) == 0) push_ch(ChSlash);
               empty_name = ($urandom_range(0, 7) == 0);
               if (!empty_name) add_letters(draw_len());
               vmode = empty_name ? $urandom_range(1, 2) : $urandom_range(0, 2);
               if (vmode == 0 && $urandom_range(0, 3) == 0) push_ch(ChSlash);
               if (vmode != 0) begin
                  push_ch(ChEq);
                  repeat ($urandom_range(0, 1)) push_ch(ChSpace);
                  if (vmode == 1) begin
                     push_ch($urandom_range(0, 7) == 0 ?
                             rand_byte_except(ChSpace, ChSlash) : ChQuote);
                     repeat (draw_len()) push_ch(rand_byte_except(ChQuote, ChQuote));
                     push_ch(ChQuote);
                  end else begin
                     push_ch(ChSlash);
                     repeat (draw_len() - 1) push_ch(rand_byte_except(ChSpace, ChGt));
                  end
               end
            end
            push_ch(ChGt);
         end
         // break the tag at one spot now and then
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(0, pend_items.size() - 1);
            pend_items[n].ch = 8'($urandom_range(0, 255));
         end
         // bytes after the end, which must give nothing
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) push_ch(8'($urandom_range(0, 255)));
      end
   endfunction

   // -------------------------------------------------------------------------
   // sender: one item per call, returns at the edge that accepts it.
   // stall is sampled at the falling edge, where everything has settled.
   // -------------------------------------------------------------------------
   task automatic send_item(input req_item_type it);
      int gap;
      bit took;
      gap = (sender_calm || hold_active) ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      sb.note_byte(it);
      items_sent++;
   endtask

   task automatic send_pending();
      foreach (pend_items[i]) send_item(pend_items[i]);
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: missing bracket on 0xFF, then a byte after the error
      pend_items.delete();
      push_ch(8'hFF);
      push_ch(8'h00);
      send_pending();
      load_text(" <a>");          // leading space, plain tag
      send_pending();
      load_text("</B ");          // closing tag ended by a space
      send_pending();
      load_text("<>");            // empty name
      send_pending();
      load_text("<a=");           // '=' in the tag name is an error
      send_pending();
      // slash ends an attribute name, '=' where a name should start,
      // unquoted value ended by '>'
      load_text("<a q/ =/v>");
      send_pending();
      // attribute without value, quoted value holding 0xFF, bad attribute start
      load_text("<i x y=\"\377\"1");
      send_pending();

      // random tags
      while (items_sent < TotalItems) begin
         build_tag();
         sender_calm = ($urandom_range(0, 3) == 0);
         if (items_sent >= TotalItems / 2 && !hold_request && !hold_active && !hold_done)
            hold_request = 1'b1;
         send_pending();
      end
      req_valid <= 1'b0;

      // wait for the tail; the watchdog guards against a hang
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.expected_tokens.size() != 0)
         $display("%0d expected results never arrived", sb.expected_tokens.size());
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // receiver: draws a stall length per result, with calm stretches and one
   // long hold-off that lets the block back up into its input
   // -------------------------------------------------------------------------
   initial begin
      int n;
      int calm_left;
      bit got;
      calm_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_active) begin
            hold_active = 1'b1;
            n = HoldCycles;
         end else if (calm_left > 0) begin
            calm_left--;
            n = 0;
         end else begin
            n = $urandom_range(0, MaxGap);
            if ($urandom_range(0, 19) == 0) calm_left = 20;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         if (hold_active) begin
            hold_active  = 1'b0;
            hold_request = 1'b0;
            hold_done    = 1'b1;
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            got = rsp_valid;
            @(posedge clock);
         end while (!got);
      end
   end

   // monitor: capture at the falling edge, check at the edge that accepts
   initial begin
      rsp_item_type seen;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen = rsp_item;
            @(posedge clock);
            sb.check_token(seen);
         end
      end
   end

   // watchdog: counts cycles in which neither channel moves an item
   initial begin
      int idle;
      idle = 0;
      while (idle < WatchdogLimit) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* html_tag_tokenizer.f */
design/htt_pkg.sv
design/htt_step.sv
design/htt_out_buf.sv
design/html_tag_tokenizer.sv
verif/tb_top.sv
